// ===== src/bs_pkg.sv =====
package bs_pkg;

    localparam int MAX_COUNT = 64;
    localparam int DATA_W    = 32;
    // Each stored word carries a padding flag above the value.
    localparam int WORD_W    = DATA_W + 1;
    localparam int ADDR_W    = $clog2(MAX_COUNT);
    localparam int DEPTH     = 1 << ADDR_W;
    localparam int CNT_W     = ADDR_W + 1;
    localparam int LVL_W     = $clog2(ADDR_W + 1);
    localparam int PAIR_W    = (ADDR_W > 1) ? ADDR_W - 1 : 1;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_LOAD,
        WR_PAD,
        WR_LOW,
        WR_PEND
    } wr_sel_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        wr_sel_t           wr_sel;
        logic [ADDR_W-1:0] wr_addr;
        logic              desc;
    } dp_cmd_t;

    // Smallest L with 2**L >= n, for n of at least one.
    function automatic logic [LVL_W-1:0] ceil_log2(input logic [CNT_W-1:0] n);
        logic [LVL_W-1:0] res;
        res = '0;
        for (int b = 0; b < ADDR_W; b++) begin
            if ((CNT_W'(1) << b) < n) begin
                res = LVL_W'(b + 1);
            end
        end
        return res;
    endfunction

endpackage

// ===== src/bs_ctrl.sv =====
module bs_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     last,
    output logic                     in_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     end_of_batch,
    output bs_pkg::dp_cmd_t          cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_FILL,
        S_SORT_RD,
        S_SORT_WR,
        S_FLUSH,
        S_OUT_RD,
        S_OUT_SHOW
    } state_t;

    state_t                          state_reg;
    logic [bs_pkg::CNT_W-1:0]        count_reg;
    logic [bs_pkg::LVL_W-1:0]        lvl_reg;
    logic [bs_pkg::LVL_W-1:0]        kb_reg;
    logic [bs_pkg::LVL_W-1:0]        jb_reg;
    logic [bs_pkg::PAIR_W-1:0]       t_reg;
    logic [bs_pkg::CNT_W-1:0]        fill_reg;
    logic [bs_pkg::ADDR_W-1:0]       o_reg;
    logic                            first_reg;

    logic                            store_ok;
    logic [bs_pkg::CNT_W-1:0]        n_next;
    logic [bs_pkg::CNT_W-1:0]        pow_p;
    logic [bs_pkg::ADDR_W-1:0]       half_m1;
    logic                            t_last;
    logic [bs_pkg::ADDR_W-1:0]       jbit;
    logic [bs_pkg::ADDR_W-1:0]       jmask;
    logic [bs_pkg::ADDR_W-1:0]       t_ext;
    logic [bs_pkg::ADDR_W-1:0]       i_addr;
    logic [bs_pkg::ADDR_W-1:0]       l_addr;
    logic [bs_pkg::CNT_W-1:0]        i_wide;
    logic                            out_last;

    assign store_ok = (count_reg < bs_pkg::CNT_W'(bs_pkg::MAX_COUNT));
    assign n_next   = count_reg + bs_pkg::CNT_W'(store_ok);
    assign pow_p    = bs_pkg::CNT_W'(1) << lvl_reg;
    assign half_m1  = bs_pkg::ADDR_W'((pow_p >> 1) - bs_pkg::CNT_W'(1));
    assign t_ext    = bs_pkg::ADDR_W'(t_reg);
    assign t_last   = (t_ext == half_m1);

    // The pair index is spread around the partner distance bit to give the
    // lower address; the partner sits at that bit set.
    assign jbit     = bs_pkg::ADDR_W'(1) << jb_reg;
    assign jmask    = jbit - bs_pkg::ADDR_W'(1);
    assign i_addr   = ((t_ext & ~jmask) << 1) | (t_ext & jmask);
    assign l_addr   = i_addr | jbit;
    assign i_wide   = bs_pkg::CNT_W'(i_addr);

    assign out_last     = (bs_pkg::CNT_W'(o_reg) == (count_reg - bs_pkg::CNT_W'(1)));
    assign in_ready     = (state_reg == S_LOAD);
    assign out_valid    = (state_reg == S_OUT_SHOW);
    assign end_of_batch = out_last;

    always_comb
    begin
        cmd.rd_en   = 1'b0;
        cmd.addr_a  = i_addr;
        cmd.addr_b  = l_addr;
        cmd.wr_sel  = bs_pkg::WR_NONE;
        cmd.wr_addr = i_addr;
        cmd.desc    = i_wide[kb_reg];
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid && store_ok)
                begin
                    cmd.wr_sel  = bs_pkg::WR_LOAD;
                    cmd.wr_addr = count_reg[bs_pkg::ADDR_W-1:0];
                end
            end
            S_FILL:
            begin
                if (fill_reg < pow_p)
                begin
                    cmd.wr_sel  = bs_pkg::WR_PAD;
                    cmd.wr_addr = fill_reg[bs_pkg::ADDR_W-1:0];
                end
            end
            S_SORT_RD:
            begin
                cmd.rd_en = 1'b1;
                if (!first_reg)
                begin
                    cmd.wr_sel = bs_pkg::WR_PEND;
                end
            end
            S_SORT_WR:
            begin
                cmd.wr_sel = bs_pkg::WR_LOW;
            end
            S_FLUSH:
            begin
                cmd.wr_sel = bs_pkg::WR_PEND;
            end
            S_OUT_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.addr_a = o_reg;
            end
            S_OUT_SHOW:
            begin
                cmd.rd_en = 1'b0;
            end
            default:
            begin
                cmd.rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            lvl_reg   <= '0;
            kb_reg    <= '0;
            jb_reg    <= '0;
            t_reg     <= '0;
            fill_reg  <= '0;
            o_reg     <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_valid)
                    begin
                        count_reg <= n_next;
                        if (last)
                        begin
                            lvl_reg   <= bs_pkg::ceil_log2(n_next);
                            fill_reg  <= n_next;
                            state_reg <= S_FILL;
                        end
                    end
                end
                S_FILL:
                begin
                    if (fill_reg < pow_p)
                    begin
                        fill_reg <= fill_reg + bs_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        kb_reg    <= bs_pkg::LVL_W'(1);
                        jb_reg    <= '0;
                        t_reg     <= '0;
                        first_reg <= 1'b1;
                        o_reg     <= '0;
                        state_reg <= (lvl_reg == '0) ? S_OUT_RD : S_SORT_RD;
                    end
                end
                S_SORT_RD:
                begin
                    state_reg <= S_SORT_WR;
                end
                S_SORT_WR:
                begin
                    first_reg <= 1'b0;
                    if (t_last)
                    begin
                        state_reg <= S_FLUSH;
                    end
                    else
                    begin
                        t_reg     <= t_reg + bs_pkg::PAIR_W'(1);
                        state_reg <= S_SORT_RD;
                    end
                end
                S_FLUSH:
                begin
                    t_reg     <= '0;
                    first_reg <= 1'b1;
                    if (jb_reg == '0)
                    begin
                        if (kb_reg == lvl_reg)
                        begin
                            o_reg     <= '0;
                            state_reg <= S_OUT_RD;
                        end
                        else
                        begin
                            kb_reg    <= kb_reg + bs_pkg::LVL_W'(1);
                            jb_reg    <= kb_reg;
                            state_reg <= S_SORT_RD;
                        end
                    end
                    else
                    begin
                        jb_reg    <= jb_reg - bs_pkg::LVL_W'(1);
                        state_reg <= S_SORT_RD;
                    end
                end
                S_OUT_RD:
                begin
                    state_reg <= S_OUT_SHOW;
                end
                S_OUT_SHOW:
                begin
                    if (out_ready)
                    begin
                        if (out_last)
                        begin
                            count_reg <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            o_reg     <= o_reg + bs_pkg::ADDR_W'(1);
                            state_reg <= S_OUT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

endmodule

// ===== src/bs_dp.sv =====
module bs_dp (
    input  logic                          clk,
    input  bs_pkg::dp_cmd_t               cmd,
    input  logic signed [bs_pkg::DATA_W-1:0] value,
    output logic [bs_pkg::WORD_W-1:0]     rd_word
);

    logic [bs_pkg::WORD_W-1:0] mem [0:bs_pkg::DEPTH-1];
    logic [bs_pkg::WORD_W-1:0] rd_a_reg;
    logic [bs_pkg::WORD_W-1:0] rd_b_reg;
    logic [bs_pkg::ADDR_W-1:0] pend_addr_reg;
    logic [bs_pkg::WORD_W-1:0] pend_data_reg;

    logic [bs_pkg::WORD_W-1:0] a_key;
    logic [bs_pkg::WORD_W-1:0] b_key;
    logic                      swap;
    logic [bs_pkg::WORD_W-1:0] low_word;
    logic [bs_pkg::WORD_W-1:0] high_word;
    logic                      wr_en;
    logic [bs_pkg::ADDR_W-1:0] wr_addr;
    logic [bs_pkg::WORD_W-1:0] wr_data;

    // Padding entries rank above every value; inverting the sign bit makes
    // an unsigned compare order the signed values.
    assign a_key = {rd_a_reg[bs_pkg::DATA_W], ~rd_a_reg[bs_pkg::DATA_W-1],
                    rd_a_reg[bs_pkg::DATA_W-2:0]};
    assign b_key = {rd_b_reg[bs_pkg::DATA_W], ~rd_b_reg[bs_pkg::DATA_W-1],
                    rd_b_reg[bs_pkg::DATA_W-2:0]};
    assign swap      = cmd.desc ? (a_key < b_key) : (a_key > b_key);
    assign low_word  = swap ? rd_b_reg : rd_a_reg;
    assign high_word = swap ? rd_a_reg : rd_b_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cmd.wr_addr;
        wr_data = low_word;
        unique case (cmd.wr_sel)
            bs_pkg::WR_NONE:
            begin
                wr_en = 1'b0;
            end
            bs_pkg::WR_LOAD:
            begin
                wr_en   = 1'b1;
                wr_data = {1'b0, value};
            end
            bs_pkg::WR_PAD:
            begin
                wr_en   = 1'b1;
                wr_data = {1'b1, {bs_pkg::DATA_W{1'b0}}};
            end
            bs_pkg::WR_LOW:
            begin
                wr_en = 1'b1;
            end
            bs_pkg::WR_PEND:
            begin
                wr_en   = 1'b1;
                wr_addr = pend_addr_reg;
                wr_data = pend_data_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_a_reg <= mem[cmd.addr_a];
            rd_b_reg <= mem[cmd.addr_b];
        end
        // The upper half of an exchange is held here and written back in the following cycle.
        if (cmd.wr_sel == bs_pkg::WR_LOW)
        begin
            pend_addr_reg <= cmd.addr_b;
            pend_data_reg <= high_word;
        end
    end

    assign rd_word = rd_a_reg;

endmodule

// ===== src/bitonic_sorter_core.sv =====
// Bitonic sorter. Values arrive one per request on the input channel and are
// stored, up to 64 per batch; further values are dropped. The request that
// carries last ends the batch: the batch of n values is padded to the next
// power of two p with entries that rank above every value, sorted by a
// bitonic network of L(L+1)/2 stages for L = log2(p), in which a single
// comparator handles the pairs of a stage one after another, reading a pair,
// then writing its lower word while the upper word waits for the one write
// port of the element memory, and then returned in ascending order on the
// output channel, each value read and then offered until it is taken, with
// end_of_batch on the last. One batch is handled at a time: no input request
// is taken between the last request of a batch and the delivery of its final
// result.
module bitonic_sorter_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [bs_pkg::DATA_W-1:0] value,
    input  logic                             last,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [bs_pkg::DATA_W-1:0] sorted_value,
    output logic                             end_of_batch
);

    bs_pkg::dp_cmd_t            cmd;
    logic [bs_pkg::WORD_W-1:0]  rd_word;

    bs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .last         (last),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .end_of_batch (end_of_batch),
        .cmd          (cmd)
    );

    bs_dp u_dp (
        .clk     (clk),
        .cmd     (cmd),
        .value   (value),
        .rd_word (rd_word)
    );

    assign sorted_value = rd_word[bs_pkg::DATA_W-1:0];

endmodule

// ===== src/bs_checker.sv =====
module bs_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             last,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic signed [bs_pkg::DATA_W-1:0] sorted_value,
    input logic                             end_of_batch
);

    // A result is never offered while input requests are still being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && in_ready))
        else $error("result offered while input is open");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(sorted_value) && $stable(end_of_batch)))
        else $error("stalled result changed");

    // A request without last leaves the block open for the next value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !last) |=> in_ready)
        else $error("input closed without end of batch");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last) |=> !in_ready)
        else $error("input open during sort");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && end_of_batch) |=> (in_ready && !out_valid))
        else $error("block not ready for a new batch");

endmodule

bind bitonic_sorter_core bs_checker u_bs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_value (sorted_value),
    .end_of_batch (end_of_batch)
);

// ===== tb/sv/bitonic_sorter_core_tb.sv =====
`timescale 1ns / 1ps

module bitonic_sorter_core_tb;

    typedef struct packed {
        logic [bs_pkg::DATA_W-1:0] val;
        logic                      eob;
    } sorted_item_t;

    typedef enum int unsigned {
        VALUES_WIDE,
        VALUES_CLUSTERED,
        VALUES_EXTREME
    } value_mix_t;

    // Keeps its own copy of the batch, sorts it with the arbitrary-length bitonic
    // network and holds the sorted values until the block returns them.
    class sort_scoreboard;
        logic signed [bs_pkg::DATA_W-1:0] batch_buf [bs_pkg::MAX_COUNT];
        int unsigned                      batch_len;
        sorted_item_t                     expected_q [$];
        int unsigned                      errors;

        function new();
            batch_len = 0;
            errors    = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void compare_swap(int unsigned a, int unsigned b, bit up);
            logic signed [bs_pkg::DATA_W-1:0] t;
            if ((batch_buf[a] > batch_buf[b]) == up)
            begin
                t            = batch_buf[a];
                batch_buf[a] = batch_buf[b];
                batch_buf[b] = t;
            end
        endfunction

        // Partners sit a distance apart equal to the largest power of two below n.
        function void merge_span(int unsigned lo, int unsigned n, bit up);
            int unsigned k;
            if (n <= 1)
                return;
            k = 1;
            while (k < n)
                k = k << 1;
            k = k >> 1;
            for (int unsigned i = lo; i < lo + n - k; i++)
                compare_swap(i, i + k, up);
            merge_span(lo, k, up);
            merge_span(lo + k, n - k, up);
        endfunction

        function void sort_span(int unsigned lo, int unsigned n, bit up);
            int unsigned h;
            if (n <= 1)
                return;
            h = n / 2;
            sort_span(lo, h, !up);
            sort_span(lo + h, n - h, up);
            merge_span(lo, n, up);
        endfunction

        function void note_request(logic signed [bs_pkg::DATA_W-1:0] v, logic l);
            sorted_item_t e;
            // Values beyond a full store are dropped, but a last flag still counts.
            if (batch_len < bs_pkg::MAX_COUNT)
            begin
                batch_buf[batch_len] = v;
                batch_len++;
            end
            if (l)
            begin
                sort_span(0, batch_len, 1'b1);
                for (int unsigned i = 0; i < batch_len; i++)
                begin
                    e.val = batch_buf[i];
                    e.eob = (i + 1 == batch_len);
                    expected_q = {expected_q, e};
                end
                batch_len = 0;
            end
        endfunction

        function void check_result(logic signed [bs_pkg::DATA_W-1:0] v, logic eob);
            sorted_item_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got value %0d eob %0b",
                         $time, v, eob);
                return;
            end
            e = expected_q.pop_front();
            if (v !== e.val)
            begin
                errors++;
                $display("%0t: sorted_value expected %0d, got %0d",
                         $time, $signed(e.val), v);
            end
            if (eob !== e.eob)
            begin
                errors++;
                $display("%0t: end_of_batch expected %0b, got %0b", $time, e.eob, eob);
            end
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic signed [bs_pkg::DATA_W-1:0] value;
    logic                             last;
    logic                             out_valid;
    logic                             out_ready;
    logic signed [bs_pkg::DATA_W-1:0] sorted_value;
    logic                             end_of_batch;

    bit             gaps_on    = 1'b1;
    int unsigned    items_sent = 0;
    sort_scoreboard sb         = new();

    bitonic_sorter_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sorted_value (sorted_value),
        .end_of_batch (end_of_batch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_request(input logic signed [bs_pkg::DATA_W-1:0] v, input logic l);
        while (gaps_on && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            value    <= $urandom;
            last     <= $urandom_range(1);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        last     <= l;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_request(v, l);
        items_sent++;
    endtask

    task automatic send_batch(input int unsigned n, input value_mix_t mix);
        logic signed [bs_pkg::DATA_W-1:0] v;
        for (int unsigned i = 0; i < n; i++)
        begin
            case (mix)
                VALUES_WIDE:      v = $urandom;
                VALUES_CLUSTERED: v = $signed($urandom_range(8)) - 4;
                default:
                begin
                    case ($urandom_range(5))
                        0:       v = 32'sh8000_0000;
                        1:       v = 32'sh7FFF_FFFF;
                        2:       v = '0;
                        3:       v = -1;
                        default: v = $urandom;
                    endcase
                end
            endcase
            send_request(v, i + 1 == n);
        end
    endtask

    // Holds the input channel idle until every outstanding result has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(sorted_value, end_of_batch);
            out_ready <= !gaps_on || ($urandom_range(99) >= 31);
        end
    end

    initial
    begin
        int unsigned batch_no;
        int unsigned size;
        int unsigned pick;

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        value    <= '0;
        last     <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-element batches at both extremes.
        send_request(32'sh7FFF_FFFF, 1'b1);
        send_request(32'sh8000_0000, 1'b1);
        // Seven values with every sign boundary in play.
        send_request(32'sh7FFF_FFFF, 1'b0);
        send_request(32'sh8000_0000, 1'b0);
        send_request(32'sh0000_0000, 1'b0);
        send_request(-32'sd1, 1'b0);
        send_request(32'sh0000_0001, 1'b0);
        send_request(32'sh5555_5555, 1'b0);
        send_request(32'shAAAA_AAAA, 1'b1);
        // Duplicates.
        send_request(32'sd5, 1'b0);
        send_request(32'sd5, 1'b0);
        send_request(-32'sd5, 1'b0);
        send_request(32'sd5, 1'b1);
        // Reverse order.
        for (int i = 6; i >= 1; i--)
            send_request(i, i == 1);
        send_request(32'sh8000_0000, 1'b0);
        send_request(32'sh8000_0000, 1'b0);
        send_request(32'sh7FFF_FFFF, 1'b1);

        wait_for_results();

        batch_no = 0;
        while (items_sent < 360)
        begin
            // The first batch overruns the store so that the last request is dropped
            // too; the second fills it exactly.
            if (batch_no == 0)
                size = bs_pkg::MAX_COUNT + 3;
            else if (batch_no == 1)
                size = bs_pkg::MAX_COUNT;
            else
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                    size = $urandom_range(12, 1);
                else if (pick < 94)
                    size = $urandom_range(40, 13);
                else
                    size = $urandom_range(bs_pkg::MAX_COUNT + 8, bs_pkg::MAX_COUNT - 4);
            end
            gaps_on = !(batch_no >= 10 && batch_no < 18);
            send_batch(size, value_mix_t'($urandom_range(2)));
            if (batch_no == 20)
                wait_for_results();
            batch_no++;
        end

        gaps_on = 1'b1;
        wait_for_results();
        repeat (300) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
